[rtl/sdtab_pkg.sv]
// Shared types, sizes and codes of the seen-device table.
`default_nettype none

package sdtab_pkg;

    // Table size and field widths
    localparam int unsigned TABLE_DEPTH     = 64;
    localparam int unsigned ADDR_W          = 48;
    localparam int unsigned TIME_W          = 32;
    localparam int unsigned CNT_OUT_W       = 7;
    localparam int unsigned STEP_W          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W           = $clog2(TABLE_DEPTH + 1);
    localparam logic [TIME_W-1:0] AGE_LIMIT_RESET = TIME_W'(40000);

    // Command codes of an input beat
    typedef enum logic {
        CMD_SIGHTING = 1'b0,
        CMD_SWEEP    = 1'b1
    } t_cmd;

    // Result status codes
    typedef enum logic [2:0] {
        STATUS_REFRESHED = 3'd0,
        STATUS_ADDED     = 3'd1,
        STATUS_FULL      = 3'd2,
        STATUS_IGNORED   = 3'd3,
        STATUS_SWEPT     = 3'd4
    } t_status;

    // Control states of the walk
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } t_state;

    // Input beat
    typedef struct packed {
        t_cmd              command;
        logic [ADDR_W-1:0] device_address;
        logic              service_match;
        logic [TIME_W-1:0] time_ms;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        t_status              status;
        logic [CNT_OUT_W-1:0] alive_count;
        logic [CNT_OUT_W-1:0] entry_count;
    } t_out_beat;

    // One table entry as held in a cell
    typedef struct packed {
        logic              used;
        logic              alive;
        logic [TIME_W-1:0] last_seen;
        logic [ADDR_W-1:0] address;
    } t_entry;

    // What the head unit reports for the entry it just handled
    typedef struct packed {
        logic hit;
        logic add;
        logic alive;
    } t_head_flags;

endpackage

`default_nettype wire

[rtl/sdtab_cell.sv]
// One table cell: holds an entry and takes its neighbor's entry on each shift.
`default_nettype none

module sdtab_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_shift,
    input  wire sdtab_pkg::t_entry i_entry,
    output sdtab_pkg::t_entry    o_entry
);
    import sdtab_pkg::*;

    logic              r_used;
    logic              r_alive;
    logic [TIME_W-1:0] r_last_seen;
    logic [ADDR_W-1:0] r_address;

    // Clear the used and alive marks at reset; advance on shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_alive <= 1'b0;
        end else if (i_shift) begin
            r_used  <= i_entry.used;
            r_alive <= i_entry.alive;
        end
    end

    // Move the payload with the marks
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_last_seen <= i_entry.last_seen;
            r_address   <= i_entry.address;
        end
    end

    assign o_entry = '{used: r_used, alive: r_alive, last_seen: r_last_seen,
                       address: r_address};

endmodule

`default_nettype wire

[rtl/sdtab_head.sv]
// Head unit: applies the current beat to the entry leaving the front cell.
`default_nettype none

module sdtab_head (
    input  wire sdtab_pkg::t_in_beat         i_job,
    input  wire [sdtab_pkg::TIME_W-1:0]      i_age_limit,
    input  wire                              i_found,
    input  wire                              i_added,
    input  wire sdtab_pkg::t_entry           i_entry,
    output sdtab_pkg::t_entry                o_entry,
    output sdtab_pkg::t_head_flags           o_flags
);
    import sdtab_pkg::*;

    logic              seek;
    logic              hit;
    logic              add;
    logic              stale;
    logic [TIME_W-1:0] age;

    // Age wraps modulo 2^32
    assign age   = i_job.time_ms - i_entry.last_seen;
    assign stale = (i_job.command == CMD_SWEEP) && i_entry.used && (age > i_age_limit);

    // Held entries come first, so the first free cell ends the search
    assign seek = (i_job.command == CMD_SIGHTING) && i_job.service_match
                  && !i_found && !i_added;
    assign hit  = seek && i_entry.used && (i_entry.address == i_job.device_address);
    assign add  = seek && !i_entry.used;

    // Rewrite the entry on a hit, an append or an expiry
    always_comb begin
        o_entry = i_entry;
        if (hit || add) begin
            o_entry.used      = 1'b1;
            o_entry.alive     = 1'b1;
            o_entry.last_seen = i_job.time_ms;
            o_entry.address   = i_job.device_address;
        end else if (stale) begin
            o_entry.alive = 1'b0;
        end
    end

    assign o_flags = '{hit: hit, add: add, alive: o_entry.used && o_entry.alive};

endmodule

`default_nettype wire

[rtl/seen_device_table_with_aging_core.sv]
// Top level of the seen-device table with aging: ring of cells and walk control.
//
//  port group   direction  handshake               payload
//  i_in         in         i_in_valid/o_in_ready   t_in_beat
//  o_out        out        o_out_valid/i_out_ready t_out_beat
//  i_cfg_wr_*   in         i_cfg_wr_en             age limit, 32 bits
//
// Each beat walks the whole ring once, one entry through the head unit per cycle
// unless the final step is stalled, and the walk returns to idle before the
// next beat is taken.
// Reset clears the used and alive marks of every cell at once; no clear pass.
// A held result does not block input; the final walk step waits while the
// previous result is still held.
`default_nettype none

module seen_device_table_with_aging_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire sdtab_pkg::t_in_beat         i_in,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output sdtab_pkg::t_out_beat             o_out,
    input  wire                              i_cfg_wr_en,
    input  wire [sdtab_pkg::TIME_W-1:0]      i_cfg_wr_data
);
    import sdtab_pkg::*;

    t_state            r_state, n_state;
    t_in_beat          r_job;
    logic [TIME_W-1:0] r_age_limit;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_found, n_found;
    logic              r_added, n_added;
    logic [CNT_W-1:0]  r_alive_cnt, n_alive_cnt;
    logic [CNT_W-1:0]  r_entries, n_entries;
    t_out_beat         r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic              in_fire;
    logic              step_last;
    logic              step_go;
    t_status           final_status;
    t_entry            head_entry;
    t_head_flags       head_flags;
    t_entry            ring [TABLE_DEPTH];

    // Ring of cells; the head unit feeds the back of the ring
    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        t_entry cell_in;
        if (gi == TABLE_DEPTH - 1) begin : g_tail
            assign cell_in = head_entry;
        end else begin : g_mid
            assign cell_in = ring[gi + 1];
        end
        sdtab_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (step_go),
            .i_entry (cell_in),
            .o_entry (ring[gi])
        );
    end

    sdtab_head u_head (
        .i_job       (r_job),
        .i_age_limit (r_age_limit),
        .i_found     (r_found),
        .i_added     (r_added),
        .i_entry     (ring[0]),
        .o_entry     (head_entry),
        .o_flags     (head_flags)
    );

    // Handshake outputs and walk progress
    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        in_fire     = i_in_valid && o_in_ready;
        step_last   = (r_step == STEP_W'(TABLE_DEPTH - 1));
        step_go     = (r_state == ST_WALK) && (!step_last || !r_out_valid || i_out_ready);
        o_out_valid = r_out_valid;
        o_out       = r_out;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_fire) n_state = ST_WALK;
            ST_WALK: if (step_go && step_last) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Pick the status of the finished beat
    always_comb begin
        if (r_job.command == CMD_SWEEP) begin
            final_status = STATUS_SWEPT;
        end else if (!r_job.service_match) begin
            final_status = STATUS_IGNORED;
        end else if (r_found || head_flags.hit) begin
            final_status = STATUS_REFRESHED;
        end else if (r_added || head_flags.add) begin
            final_status = STATUS_ADDED;
        end else begin
            final_status = STATUS_FULL;
        end
    end

    // Walk counters, search flags and the result register
    always_comb begin
        n_step      = r_step;
        n_found     = r_found;
        n_added     = r_added;
        n_alive_cnt = r_alive_cnt;
        n_entries   = r_entries;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        if (in_fire) begin
            n_step      = '0;
            n_found     = 1'b0;
            n_added     = 1'b0;
            n_alive_cnt = '0;
        end else if (step_go) begin
            n_step      = step_last ? '0 : r_step + STEP_W'(1);
            n_found     = r_found || head_flags.hit;
            n_added     = r_added || head_flags.add;
            n_alive_cnt = r_alive_cnt + CNT_W'(head_flags.alive);
            n_entries   = r_entries + CNT_W'(head_flags.add);
            if (step_last) begin
                n_out_valid       = 1'b1;
                n_out.status      = final_status;
                n_out.alive_count = CNT_OUT_W'(n_alive_cnt);
                n_out.entry_count = CNT_OUT_W'(n_entries);
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_found     <= 1'b0;
            r_added     <= 1'b0;
            r_alive_cnt <= '0;
            r_entries   <= '0;
            r_out_valid <= 1'b0;
            r_age_limit <= AGE_LIMIT_RESET;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_found     <= n_found;
            r_added     <= n_added;
            r_alive_cnt <= n_alive_cnt;
            r_entries   <= n_entries;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_age_limit <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_job <= i_in;
        end
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_accept_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_WALK) && (r_step == '0))
        else $error("accepted beat did not start a walk");

    a_entries_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entries <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_alive_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alive_cnt <= r_entries)
        else $error("alive count beyond entry count");

    a_single_search_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_found && r_added))
        else $error("beat both refreshed and appended an entry");

    a_idle_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_step == '0))
        else $error("walk counter not parked while idle");
`endif

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the seen-device table with aging.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sdtab_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_PRINTED    = 100;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    t_in_beat             in_beat     = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 out_ready   = 1'b0;
    t_out_beat            o_out;
    logic                 cfg_wr_en   = 1'b0;
    logic [TIME_W-1:0]    cfg_wr_data = '0;

    // Predicted table contents and the current age limit
    logic [ADDR_W-1:0]    tbl_addr  [TABLE_DEPTH];
    logic [TIME_W-1:0]    tbl_seen  [TABLE_DEPTH];
    logic                 tbl_alive [TABLE_DEPTH];
    int                   tbl_used  = 0;
    logic [TIME_W-1:0]    age_limit = AGE_LIMIT_RESET;

    t_out_beat            table_replies_due[$];
    t_out_beat            reply_due;
    logic [ADDR_W-1:0]    address_pool[$];
    logic [TIME_W-1:0]    now_ms       = '0;
    int                   mismatch_count = 0;
    int                   burst_left   = 0;
    int                   idle_cycles  = 0;
    int                   stall_left   = 0;
    int                   ready_mode   = 0;
    int                   mode_left    = 0;

    seen_device_table_with_aging_core i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_in          (in_beat),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_out         (o_out),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Apply one beat to the predicted table and return the reply it should cause
    function automatic t_out_beat next_table_reply(input t_in_beat beat);
        t_out_beat         reply;
        logic [TIME_W-1:0] age;
        int                alive_n;
        bit                hit;
        reply = '0;
        if (beat.command == CMD_SWEEP) begin
            for (int k = 0; k < tbl_used; k++) begin
                age = beat.time_ms - tbl_seen[k];
                if (age > age_limit) tbl_alive[k] = 1'b0;
            end
            reply.status = STATUS_SWEPT;
        end else if (!beat.service_match) begin
            reply.status = STATUS_IGNORED;
        end else begin
            hit = 1'b0;
            for (int k = 0; k < tbl_used; k++) begin
                if (!hit && tbl_addr[k] == beat.device_address) begin
                    hit          = 1'b1;
                    tbl_seen[k]  = beat.time_ms;
                    tbl_alive[k] = 1'b1;
                end
            end
            if (hit) begin
                reply.status = STATUS_REFRESHED;
            end else if (tbl_used >= TABLE_DEPTH) begin
                reply.status = STATUS_FULL;
            end else begin
                tbl_addr[tbl_used]  = beat.device_address;
                tbl_seen[tbl_used]  = beat.time_ms;
                tbl_alive[tbl_used] = 1'b1;
                tbl_used++;
                reply.status = STATUS_ADDED;
            end
        end
        alive_n = 0;
        for (int k = 0; k < tbl_used; k++) alive_n += tbl_alive[k];
        reply.alive_count = CNT_OUT_W'(alive_n);
        reply.entry_count = CNT_OUT_W'(tbl_used);
        return reply;
    endfunction

    function automatic t_in_beat mk_beat(input t_cmd cmd, input logic [ADDR_W-1:0] addr,
                                         input logic match, input logic [TIME_W-1:0] ms);
        t_in_beat beat;
        beat.command        = cmd;
        beat.device_address = addr;
        beat.service_match  = match;
        beat.time_ms        = ms;
        return beat;
    endfunction

    // Print one mismatch line (log kept short) and count it
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Send one beat in bursts with random gaps, then record its predicted reply
    task automatic send_beat(input t_in_beat beat);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
        end else begin
            gap = 0;
        end
        burst_left--;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        do @(posedge clk); while (!o_in_ready);
        table_replies_due.push_back(next_table_reply(beat));
    endtask

    // Hold off input until every due reply has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (table_replies_due.size() != 0);
    endtask

    // Drain, then let the walk finish before touching the register
    task automatic settle_idle();
        drain_results();
        repeat (TABLE_DEPTH + 4) @(posedge clk);
    endtask

    task automatic write_age_limit(input logic [TIME_W-1:0] limit);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        age_limit    = limit;
    endtask

    // Ignored sightings, an early sweep, first adds, wrap of address and time, exact address compare
    task automatic test_sighting_basics();
        send_beat(mk_beat(CMD_SIGHTING, '1, 1'b0, '0));
        send_beat(mk_beat(CMD_SWEEP, ADDR_W'({$urandom, $urandom}), 1'b1, '0));
        send_beat(mk_beat(CMD_SIGHTING, '0, 1'b1, '0));
        send_beat(mk_beat(CMD_SIGHTING, '1, 1'b1, '1));
        send_beat(mk_beat(CMD_SIGHTING, 48'h8000_0000_0000, 1'b1, 32'd5));
        send_beat(mk_beat(CMD_SIGHTING, '0, 1'b1, 32'd100));
        send_beat(mk_beat(CMD_SIGHTING, '0, 1'b0, 32'd30000));
    endtask

    // Age exactly at the limit survives, one past it dies, a sighting revives
    task automatic test_sweep_aging();
        send_beat(mk_beat(CMD_SWEEP, '0, 1'b0, 32'd40100));
        send_beat(mk_beat(CMD_SWEEP, ADDR_W'({$urandom, $urandom}), 1'b1, 32'd40101));
        send_beat(mk_beat(CMD_SIGHTING, '1, 1'b1, 32'd40200));
    endtask

    // Zero limit kills anything older than now; full limit kills nothing
    task automatic test_age_limit_extremes();
        settle_idle();
        write_age_limit('0);
        send_beat(mk_beat(CMD_SIGHTING, '0, 1'b1, 32'd50000));
        send_beat(mk_beat(CMD_SWEEP, '1, 1'b1, 32'd50000));
        send_beat(mk_beat(CMD_SWEEP, '0, 1'b0, 32'd50001));
        settle_idle();
        write_age_limit('1);
        send_beat(mk_beat(CMD_SIGHTING, '0, 1'b1, '0));
        send_beat(mk_beat(CMD_SIGHTING, 48'h8000_0000_0000, 1'b1, 32'd1));
        send_beat(mk_beat(CMD_SWEEP, '0, 1'b0, '1));
    endtask

    // Mostly matching sightings of known devices, some new ones, sweeps and noise
    task automatic test_random_traffic(input logic [TIME_W-1:0] limit,
                                       input int unsigned step_max, input int items);
        t_in_beat beat;
        int       done;
        int       pick;
        int       span;
        settle_idle();
        write_age_limit(limit);
        done = 0;
        while (done < items) begin
            if ($urandom_range(0, 49) == 0) now_ms = $urandom;
            else now_ms += $urandom_range(0, step_max);
            beat.command        = CMD_SIGHTING;
            beat.service_match  = 1'b1;
            beat.time_ms        = ($urandom_range(0, 39) == 0) ? $urandom : now_ms;
            beat.device_address = ADDR_W'({$urandom, $urandom});
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                beat.command       = CMD_SWEEP;
                beat.service_match = 1'($urandom_range(0, 1));
            end else if (pick < 18) begin
                beat.service_match = 1'b0;
                if (address_pool.size() != 0 && $urandom_range(0, 1))
                    beat.device_address =
                        address_pool[$urandom_range(0, address_pool.size() - 1)];
            end else if (address_pool.size() == 0 || pick < 25) begin
                address_pool.push_back(beat.device_address);
            end else if (pick < 27) begin
                // one flipped bit must not match the original device
                beat.device_address =
                    address_pool[$urandom_range(0, address_pool.size() - 1)]
                    ^ (ADDR_W'(1) << $urandom_range(0, ADDR_W - 1));
                address_pool.push_back(beat.device_address);
            end else if (pick < 65) begin
                span = (address_pool.size() < 8) ? address_pool.size() : 8;
                beat.device_address =
                    address_pool[address_pool.size() - 1 - $urandom_range(0, span - 1)];
            end else begin
                beat.device_address =
                    address_pool[$urandom_range(0, address_pool.size() - 1)];
            end
            send_beat(beat);
            if (beat.command == CMD_SWEEP || beat.service_match) done++;
            if ($urandom_range(0, 299) == 0) drain_results();
        end
    endtask

    // Receiver stall pattern: always ready, coin flip, or rare long stalls
    always @(posedge clk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(200, 1500);
        end
        mode_left--;
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            case (ready_mode)
                0: begin
                    out_ready <= 1'b1;
                end
                1: begin
                    out_ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    if ($urandom_range(0, 19) == 0) begin
                        stall_left = $urandom_range(10, 80);
                        out_ready <= 1'b0;
                    end else begin
                        out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Compare each result beat with the oldest due reply
    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            if (table_replies_due.size() == 0) begin
                report_mismatch("result beat with nothing due", o_out, 0);
            end else begin
                reply_due = table_replies_due.pop_front();
                if (o_out.status !== reply_due.status)
                    report_mismatch("status", o_out.status, reply_due.status);
                if (o_out.alive_count !== reply_due.alive_count)
                    report_mismatch("alive_count", o_out.alive_count, reply_due.alive_count);
                if (o_out.entry_count !== reply_due.entry_count)
                    report_mismatch("entry_count", o_out.entry_count, reply_due.entry_count);
            end
        end
    end

    // End the run if no beat moves on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        logic [TIME_W-1:0] wide_limit;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_sighting_basics();
        test_sweep_aging();
        test_age_limit_extremes();
        test_random_traffic(32'd40000, 12000, 600);
        test_random_traffic('0, 3, 250);
        test_random_traffic('1, 200000, 250);
        wide_limit = $urandom_range(1000, 2000000);
        test_random_traffic(wide_limit, wide_limit >> 2, 400);
        wide_limit = $urandom;
        test_random_traffic(wide_limit, $urandom, 200);
        test_random_traffic(32'd40000, 12000, 300);
        settle_idle();
        if (mismatch_count == 0 && table_replies_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[seen_device_table_with_aging_core.f]
rtl/sdtab_pkg.sv
rtl/sdtab_cell.sv
rtl/sdtab_head.sv
rtl/seen_device_table_with_aging_core.sv
tb/tb_top.sv
